// ----- design/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLen,
    StCompress,
    StFinish,
    StOut
  } state_e;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- design/sha256_stream_hasher.sv -----
// SHA-256 over a byte stream. Each transaction on the slave side carries one
// byte (tdata), a byte-valid flag (tuser) and tlast, which closes the message;
// an item with tuser low and tlast high closes it without adding a byte. A
// byte that does not complete a block leaves the unit ready for the next. The
// 64th byte of a block starts the compression, one round per cycle on a single
// round unit with a 16-word rolling schedule, and no input is taken until the
// compression ends. On tlast the unit appends 0x80, zero padding and the
// 64-bit length one byte a cycle outside compressions, compresses one or two
// further blocks, then presents the eight digest words on the master side,
// word 0 first, tlast on the eighth. No input is taken from tlast until the
// last digest word has been accepted.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero
  output logic        m_axis_tlast    // last_word
);

  state_e state_q, state_d;
  state_e ret_q, ret_d;     // where to go after a compression
  word_t  hash_q [8];
  word_t  wrk_q  [8];
  word_t  w_q    [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  round_q;
  logic [2:0]  cnt_q;       // length byte index, then output word index
  logic        pad_first_q;

  logic       put_en;
  logic [7:0] put_byte;

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser && fill_q == 6'd63) begin
            state_d = StCompress;
            ret_d   = s_axis_tlast ? StPad : StIdle;
          end else if (s_axis_tlast) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        // The 0x80 byte is the first pad byte, chosen by a flag below.
        if (fill_q == 6'd63) begin
          state_d = StCompress;
          ret_d   = StPad;
        end else if (fill_q == 6'd55 || (fill_q == 6'd56 && !pad_first_q)) begin
          state_d = (fill_q == 6'd55) ? StLen : StLen;
        end
      end
      StLen: begin
        if (cnt_q == 3'd7) begin
          state_d = StCompress;
          ret_d   = StFinish;
        end
      end
      StCompress: begin
        if (round_q == 6'd63) state_d = ret_q;
      end
      StFinish: state_d = StOut;
      StOut: begin
        if (m_axis_tready && cnt_q == 3'd7) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready = (state_q == StIdle);
    m_axis_tvalid = (state_q == StOut);
    m_axis_tdata  = {5'd0, cnt_q, hash_q[cnt_q]};
    m_axis_tlast  = (cnt_q == 3'd7);
    put_en   = 1'b0;
    put_byte = s_axis_tdata;
    case (state_q)
      StIdle: put_en = s_axis_tvalid && s_axis_tuser;
      StPad: begin
        // Pad bytes go in until the fill reaches 56; after a compression mid-padding
        // the fill is 0 and padding resumes, with zeros once the 0x80 is in.
        put_en   = pad_first_q || (fill_q != 6'd56);
        put_byte = pad_first_q ? PadByte : 8'h00;
      end
      StLen: begin
        put_en   = 1'b1;
        put_byte = bits_q[(7 - cnt_q) * 8 +: 8];
      end
      default: ;
    endcase
  end

  // Round datapath: one round per cycle, schedule rolled in w_q.
  word_t t1, t2, wnew;
  always_comb begin
    t1 = wrk_q[7] + bsig1(wrk_q[4]) + ((wrk_q[4] & wrk_q[5]) ^ (~wrk_q[4] & wrk_q[6]))
       + RoundConst[round_q] + w_q[0];
    t2 = bsig0(wrk_q[0]) + ((wrk_q[0] & wrk_q[1]) ^ (wrk_q[0] & wrk_q[2])
       ^ (wrk_q[1] & wrk_q[2]));
    wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
  end

  logic [3:0] widx;
  logic [1:0] bpos;
  assign widx = fill_q[5:2];
  assign bpos = fill_q[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      fill_q      <= '0;
      bits_q      <= '0;
      round_q     <= '0;
      cnt_q       <= '0;
      pad_first_q <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (state_q == StIdle && s_axis_tvalid) begin
        if (s_axis_tuser) bits_q <= bits_q + 64'd8;
        pad_first_q <= s_axis_tlast;
        cnt_q <= '0;
      end
      if (put_en) begin
        fill_q <= fill_q + 6'd1;
        if (state_q == StPad) pad_first_q <= 1'b0;
        if (state_q == StLen) cnt_q <= cnt_q + 3'd1;
      end
      if (put_en && fill_q == 6'd63) begin
        round_q <= '0;
        for (int i = 0; i < 8; i++) wrk_q[i] <= hash_q[i];
      end
      if (state_q == StCompress) begin
        round_q <= round_q + 6'd1;
        wrk_q[0] <= t1 + t2;
        wrk_q[1] <= wrk_q[0];
        wrk_q[2] <= wrk_q[1];
        wrk_q[3] <= wrk_q[2];
        wrk_q[4] <= wrk_q[3] + t1;
        wrk_q[5] <= wrk_q[4];
        wrk_q[6] <= wrk_q[5];
        wrk_q[7] <= wrk_q[6];
        if (round_q == 6'd63) begin
          hash_q[0] <= hash_q[0] + t1 + t2;
          hash_q[1] <= hash_q[1] + wrk_q[0];
          hash_q[2] <= hash_q[2] + wrk_q[1];
          hash_q[3] <= hash_q[3] + wrk_q[2];
          hash_q[4] <= hash_q[4] + wrk_q[3] + t1;
          hash_q[5] <= hash_q[5] + wrk_q[4];
          hash_q[6] <= hash_q[6] + wrk_q[5];
          hash_q[7] <= hash_q[7] + wrk_q[6];
        end
      end
      if (state_q == StFinish) begin
        cnt_q  <= '0;
        bits_q <= '0;
      end
      if (state_q == StOut && m_axis_tready) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
        end
      end
    end
  end

  // Message words: byte packing, then rolled during compression.
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      if (bpos == 2'd0) w_q[widx] <= {put_byte, 24'd0};
      else w_q[widx][(3 - bpos) * 8 +: 8] <= put_byte;
    end else if (state_q == StCompress) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output active together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCompress && round_q != 6'd63) |=> state_q == StCompress)
    else $error("compression left early");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLen) |-> fill_q[5:3] == 3'd7)
    else $error("length bytes misplaced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCompress) |-> fill_q == 6'd0)
    else $error("fill not cleared at compression");

endmodule

// ----- tb/tb_sha256_stream_hasher.sv -----
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Predicted hasher state.
  word_t       chain_hash [8];
  word_t       msg_words [16];
  int unsigned fill_bytes;
  logic [63:0] msg_bits;

  digest_item_t expected_digests [$];
  int unsigned  error_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  messages_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  burst_left = 0;
  bit           hold_sink = 1'b0;

  sha256_stream_hasher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic word_t ror32(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_words();
    word_t sched [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = msg_words[i];
    for (int i = 16; i < 64; i++) begin
      sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
               + sched[i-7]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + sched[i-16];
    end
    {a, b, c, d, e, f, g, h} = {chain_hash[0], chain_hash[1], chain_hash[2], chain_hash[3],
                                chain_hash[4], chain_hash[5], chain_hash[6], chain_hash[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[i] + sched[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endtask

  task automatic absorb_byte(logic [7:0] value);
    int unsigned shift;
    shift = (3 - (fill_bytes % 4)) * 8;
    if (fill_bytes % 4 == 0) msg_words[fill_bytes / 4] = '0;
    msg_words[fill_bytes / 4] |= word_t'(value) << shift;
    fill_bytes++;
    if (fill_bytes == 64) begin
      compress_words();
      fill_bytes = 0;
    end
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_hash[i] = InitHash[i];
    fill_bytes = 0;
    msg_bits = '0;
  endtask

  task automatic predict_item(logic [7:0] data, logic valid, logic last);
    digest_item_t item;
    if (valid) begin
      absorb_byte(data);
      msg_bits += 64'd8;
    end
    if (last) begin
      absorb_byte(PadByte);
      while (fill_bytes != 56) absorb_byte(8'h00);
      for (int k = 7; k >= 0; k--) absorb_byte(msg_bits[k*8 +: 8]);
      for (int k = 0; k < 8; k++) begin
        item = '{chain_hash[k], 3'(k), k == 7};
        expected_digests = {expected_digests, item};
      end
      messages_sent++;
      restart_hash();
    end
  endtask

  // Sender bursts: a random gap, sometimes none, then a random-length burst.
  task automatic send_item(logic [7:0] data, logic valid, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(data, valid, last);
    if (valid) bytes_sent++;
  endtask

  task automatic send_message(int unsigned len, bit closing_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && closing_byte);
    if (!closing_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);                 // empty message
    send_item(8'hFF, 1'b1, 1'b1);                 // single byte on closing item
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);                 // ignored item mid-message
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);                 // "abc"
  endtask

  // Lengths around the one- and two-block padding boundaries.
  task automatic test_block_boundaries();
    send_message(56, 1'b0);
    send_message(64, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned remaining;
    remaining = 10;
    while (remaining > 0) begin
      int unsigned len;
      len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 70) : $urandom_range(0, 12);
      if (len > remaining) len = remaining;
      send_message(len, 1'($urandom_range(0, 1)));
      remaining -= (len == 0) ? 1 : len;
    end
  endtask

  // Long sink hold-off while several messages queue up behind it.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_message($urandom_range(0, 5), 1'b1);
    join
  endtask

  always @(posedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 15) < 10) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      digest_item_t got, want;
      got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
      if (expected_digests.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_digests.pop_front();
        words_checked++;
        if (got.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                   got.digest_word);
          error_count++;
        end
        if (got.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
                   got.word_index);
          error_count++;
        end
        if (got.last_word !== want.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time, want.last_word,
                   got.last_word);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("sha256_stream_hasher test failed");
      $finish;
    end
  end

  initial begin
    restart_hash();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_boundaries();
    test_backpressure();
    test_random_messages();
    s_axis_tvalid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Hashed %0d messages (%0d bytes), %0d digest words checked.", messages_sent,
             bytes_sent, words_checked);
    if (error_count == 0) begin
      $display("sha256_stream_hasher test passed");
    end else begin
      $display("sha256_stream_hasher test failed");
    end
    $finish;
  end

endmodule
